// File: rtl/core/ibl_pkg.sv
// Shared types and constants for the isochronous batch lifecycle tracker.
// Holds event codes, phase codes, the one-hot phase type and the cell control struct.
// No dependencies.
package ibl_pkg;

	// Tag list geometry
	localparam int LIST_DEPTH = 8;
	localparam int OCC_W      = $clog2(LIST_DEPTH + 1);
	localparam int TAG_W      = 32;
	localparam int MODE_W     = 3;
	localparam int PHASE_W    = 3;
	localparam int OCC_OUT_W  = 4;

	// Event codes
	localparam logic [MODE_W-1:0] MODE_ADD         = 3'd0;
	localparam logic [MODE_W-1:0] MODE_START       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QUEUE       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COMPLETE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BEGIN_STOP  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FINISH_STOP = 3'd5;
	localparam logic [MODE_W-1:0] MODE_REMOVE      = 3'd6;

	// Encoded phase as shown on the result channel
	localparam logic [PHASE_W-1:0] PH_CODE_FREE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CODE_ADDED    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CODE_RUNNING  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CODE_STOPPING = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CODE_STOPPED  = 3'd4;

	// Stream phase, one-hot
	typedef enum logic [4:0] {
		PH_FREE     = 5'b00001,
		PH_ADDED    = 5'b00010,
		PH_RUNNING  = 5'b00100,
		PH_STOPPING = 5'b01000,
		PH_STOPPED  = 5'b10000
	} phase_t;

	// Control broadcast to every cell of the tag row
	typedef struct packed {
		logic             clear;
		logic             push;
		logic             pull;
		logic [TAG_W-1:0] tag_new;
		logic [TAG_W-1:0] key;
	} cell_ctrl_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
		logic [PHASE_W-1:0] c;
		case (p)
			PH_FREE:     c = PH_CODE_FREE;
			PH_ADDED:    c = PH_CODE_ADDED;
			PH_RUNNING:  c = PH_CODE_RUNNING;
			PH_STOPPING: c = PH_CODE_STOPPING;
			PH_STOPPED:  c = PH_CODE_STOPPED;
			default:     c = PH_CODE_FREE;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/ibl_if.sv
// Valid/ready channel interfaces for events in and results out.
// Depends on ibl_pkg for field widths.
interface ibl_ev_if;
	logic                        valid;
	logic                        ready;
	logic [ibl_pkg::MODE_W-1:0]  mode;
	logic [ibl_pkg::TAG_W-1:0]   tag_in;

	modport source (output valid, mode, tag_in, input ready);
	modport sink   (input valid, mode, tag_in, output ready);
endinterface

interface ibl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [ibl_pkg::TAG_W-1:0]     new_tag;
	logic [ibl_pkg::PHASE_W-1:0]   phase_now;
	logic [ibl_pkg::OCC_OUT_W-1:0] occupancy_now;

	modport source (output valid, accepted, new_tag, phase_now, occupancy_now, input ready);
	modport sink   (input valid, accepted, new_tag, phase_now, occupancy_now, output ready);
endinterface

// File: rtl/core/ibl_cell.sv
// One slot of the tag row: holds a tag, takes a pushed tag when it is the first
// empty slot, and takes its upper neighbor's tag when a completed tag lies at or below it.
// Depends on ibl_pkg.
module ibl_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ibl_pkg::cell_ctrl_t        ctrl,
	input  logic                       prev_busy,
	input  logic                       hit_in,
	input  logic [ibl_pkg::TAG_W-1:0]  next_entry,
	output logic                       hit_out,
	output logic [ibl_pkg::TAG_W-1:0]  entry
);

	logic [ibl_pkg::TAG_W-1:0] entry_q;
	logic                      empty;

	assign empty   = (entry_q == '0);
	// Pass on whether the key sits here or in a lower slot
	assign hit_out = hit_in | (entry_q == ctrl.key);
	assign entry   = entry_q;

	// Clear, append, or close the gap left by a completed tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.clear) begin
			entry_q <= '0;
		end else if (ctrl.push && empty && prev_busy) begin
			entry_q <= ctrl.tag_new;
		end else if (ctrl.pull && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// File: rtl/core/ibl_chain.sv
// Row of LIST_DEPTH tag cells linked to their neighbors.
// Reports whether the key was found and whether the row is full.
// Depends on ibl_pkg and ibl_cell.
module ibl_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  ibl_pkg::cell_ctrl_t ctrl,
	output logic                found,
	output logic                full
);

	logic [ibl_pkg::TAG_W-1:0] ent [ibl_pkg::LIST_DEPTH+1];
	logic                      hit [ibl_pkg::LIST_DEPTH+1];
	logic                      busy [ibl_pkg::LIST_DEPTH+1];

	// Boundary values: nothing below the first cell, empty beyond the last
	assign hit[0]                    = 1'b0;
	assign busy[0]                   = 1'b1;
	assign ent[ibl_pkg::LIST_DEPTH]  = '0;

	for (genvar i = 0; i < ibl_pkg::LIST_DEPTH; i++) begin : g_cell
		logic [ibl_pkg::TAG_W-1:0] cell_entry;

		ibl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_busy  (busy[i]),
			.hit_in     (hit[i]),
			.next_entry (ent[i+1]),
			.hit_out    (hit[i+1]),
			.entry      (cell_entry)
		);

		assign ent[i]    = cell_entry;
		assign busy[i+1] = (cell_entry != '0);
	end

	assign found = hit[ibl_pkg::LIST_DEPTH] & (ctrl.key != '0) & (ent[0] != '0);
	assign full  = busy[ibl_pkg::LIST_DEPTH];

endmodule

// File: rtl/core/iso_batch_lifecycle_tracker.sv
// Isochronous stream lifecycle and in-flight batch tag tracker, top level.
// The result is registered and becomes valid in the cycle after the event transfer; one event per cycle
// is sustained while the result channel does not stall, with the compare and shift across the tag cell row.
// The result register accepts a new event while its result is taken the same cycle.
// Reset (arst_n low, asynchronous): phase free, tag counter zero, row empty, no result.
// Depends on ibl_pkg, ibl_if, ibl_chain.
module iso_batch_lifecycle_tracker (
	input  logic       clk,
	input  logic       arst_n,
	ibl_ev_if.sink     ev,
	ibl_rsp_if.source  rsp
);

	ibl_pkg::phase_t             phase_q, phase_d;
	logic [ibl_pkg::TAG_W-1:0]   next_tag_q, next_tag_d;
	logic [ibl_pkg::OCC_W-1:0]   occ_q, occ_d;
	logic                        ok;
	logic [ibl_pkg::TAG_W-1:0]   given;
	logic                        xfer;
	logic                        found;
	logic                        full;
	ibl_pkg::cell_ctrl_t         ctrl;

	logic                          rsp_vld_q;
	logic                          acc_q;
	logic [ibl_pkg::TAG_W-1:0]     new_tag_q;
	logic [ibl_pkg::PHASE_W-1:0]   phase_now_q;
	logic [ibl_pkg::OCC_OUT_W-1:0] occ_now_q;

	assign ev.ready = !rsp_vld_q || rsp.ready;
	assign xfer     = ev.valid && ev.ready;

	ibl_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.found  (found),
		.full   (full)
	);

	// Decode the event against the current phase
	always_comb begin
		phase_d      = phase_q;
		next_tag_d   = next_tag_q;
		occ_d        = occ_q;
		ok           = 1'b0;
		given        = '0;
		ctrl.clear   = 1'b0;
		ctrl.push    = 1'b0;
		ctrl.pull    = 1'b0;
		ctrl.key     = ev.tag_in;
		ctrl.tag_new = (next_tag_q == '0) ? ibl_pkg::TAG_W'(1) : next_tag_q;
		case (ev.mode)
			ibl_pkg::MODE_ADD: begin
				if (phase_q == ibl_pkg::PH_FREE) begin
					ok         = 1'b1;
					phase_d    = ibl_pkg::PH_ADDED;
					next_tag_d = ibl_pkg::TAG_W'(1);
				end
			end
			ibl_pkg::MODE_START: begin
				if (phase_q == ibl_pkg::PH_ADDED || phase_q == ibl_pkg::PH_STOPPED) begin
					ok         = 1'b1;
					phase_d    = ibl_pkg::PH_RUNNING;
					occ_d      = '0;
					ctrl.clear = 1'b1;
				end
			end
			ibl_pkg::MODE_QUEUE: begin
				if (phase_q == ibl_pkg::PH_RUNNING && !full) begin
					ok         = 1'b1;
					given      = ctrl.tag_new;
					next_tag_d = ctrl.tag_new + ibl_pkg::TAG_W'(1);
					occ_d      = occ_q + ibl_pkg::OCC_W'(1);
					ctrl.push  = 1'b1;
				end
			end
			ibl_pkg::MODE_COMPLETE: begin
				if (phase_q == ibl_pkg::PH_RUNNING && found) begin
					ok        = 1'b1;
					occ_d     = occ_q - ibl_pkg::OCC_W'(1);
					ctrl.pull = 1'b1;
				end
			end
			ibl_pkg::MODE_BEGIN_STOP: begin
				if (phase_q == ibl_pkg::PH_RUNNING) begin
					ok      = 1'b1;
					phase_d = ibl_pkg::PH_STOPPING;
				end
			end
			ibl_pkg::MODE_FINISH_STOP: begin
				if (phase_q == ibl_pkg::PH_STOPPING) begin
					ok         = 1'b1;
					phase_d    = ibl_pkg::PH_STOPPED;
					occ_d      = '0;
					ctrl.clear = 1'b1;
				end
			end
			ibl_pkg::MODE_REMOVE: begin
				if (phase_q == ibl_pkg::PH_ADDED || phase_q == ibl_pkg::PH_STOPPED) begin
					ok         = 1'b1;
					phase_d    = ibl_pkg::PH_FREE;
					next_tag_d = '0;
					occ_d      = '0;
					ctrl.clear = 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		// Apply cell updates only on a transfer
		ctrl.clear = ctrl.clear & xfer;
		ctrl.push  = ctrl.push & xfer;
		ctrl.pull  = ctrl.pull & xfer;
	end

	// Advance stream state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ibl_pkg::PH_FREE;
			next_tag_q <= '0;
			occ_q      <= '0;
		end else if (xfer) begin
			phase_q    <= phase_d;
			next_tag_q <= next_tag_d;
			occ_q      <= occ_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (xfer) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			acc_q       <= ok;
			new_tag_q   <= given;
			phase_now_q <= ibl_pkg::phase_code(phase_d);
			occ_now_q   <= ibl_pkg::OCC_OUT_W'(occ_d);
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.accepted      = acc_q;
	assign rsp.new_tag       = new_tag_q;
	assign rsp.phase_now     = phase_now_q;
	assign rsp.occupancy_now = occ_now_q;

endmodule

// File: rtl/core/ibl_checker.sv
// Port-level checks for the batch lifecycle tracker, bound to the top level.
// Depends on ibl_pkg.
module ibl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          accepted,
	input logic [ibl_pkg::TAG_W-1:0]     new_tag,
	input logic [ibl_pkg::PHASE_W-1:0]   phase_now,
	input logic [ibl_pkg::OCC_OUT_W-1:0] occupancy_now
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_tag) && $stable(phase_now)
			&& $stable(occupancy_now) && $stable(accepted))
		else $error("result changed while stalled");

	// A refused event hands out no tag
	a_refused_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !accepted |-> new_tag == '0)
		else $error("refused event carries a tag");

	// A tag is handed out only by an accepted queue while running
	a_tag_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && new_tag != '0 |-> accepted && phase_now == ibl_pkg::PH_CODE_RUNNING
			&& occupancy_now != '0)
		else $error("tag handed out outside running");

	// Tags in flight only while running or stopping, never beyond the row
	a_occ_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && occupancy_now != '0 |->
			(phase_now == ibl_pkg::PH_CODE_RUNNING || phase_now == ibl_pkg::PH_CODE_STOPPING)
			&& 32'(occupancy_now) <= 32'(ibl_pkg::LIST_DEPTH))
		else $error("occupancy inconsistent with phase or depth");

endmodule

bind iso_batch_lifecycle_tracker ibl_checker u_ibl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.accepted      (rsp.accepted),
	.new_tag       (rsp.new_tag),
	.phase_now     (rsp.phase_now),
	.occupancy_now (rsp.occupancy_now)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for iso_batch_lifecycle_tracker: lifecycle events with tag queue/complete.
// Depends on ibl_pkg, ibl_if and the tracker RTL; a scoreboard class predicts every result.
module tb;
	import ibl_pkg::*;

	// Event code with no meaning in the block; always refused
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	localparam int RANDOM_EVENTS   = 1426;
	localparam int RSP_HOLD_CYCLES = 120;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic                 accepted;
		logic [TAG_W-1:0]     new_tag;
		logic [PHASE_W-1:0]   phase_now;
		logic [OCC_OUT_W-1:0] occupancy_now;
	} stream_status_t;

	// Predicts the stream state and holds the results still to arrive
	class lifecycle_scoreboard;
		logic [PHASE_W-1:0] phase;
		logic [TAG_W-1:0]   next_tag;
		logic [TAG_W-1:0]   tags[LIST_DEPTH];
		int unsigned        occ;
		stream_status_t     status_q[$];
		int unsigned        errors;

		function new();
			errors = 0;
			clear_stream();
		endfunction

		function void clear_tags();
			for (int i = 0; i < LIST_DEPTH; i++)
				tags[i] = '0;
			occ = 0;
		endfunction

		function void clear_stream();
			phase    = PH_CODE_FREE;
			next_tag = '0;
			clear_tags();
		endfunction

		function int pending_count();
			return status_q.size();
		endfunction

		// Apply one transferred event and queue the status it should produce
		function void note_event(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t);
			stream_status_t exp;
			int             hit;
			exp = '0;
			case (m)
				MODE_ADD: begin
					if (phase == PH_CODE_FREE) begin
						phase        = PH_CODE_ADDED;
						next_tag     = 1;
						exp.accepted = 1'b1;
					end
				end
				MODE_START: begin
					if (phase == PH_CODE_ADDED || phase == PH_CODE_STOPPED) begin
						clear_tags();
						phase        = PH_CODE_RUNNING;
						exp.accepted = 1'b1;
					end
				end
				MODE_QUEUE: begin
					if (phase == PH_CODE_RUNNING && occ < LIST_DEPTH) begin
						exp.new_tag = next_tag;
						next_tag    = next_tag + 1;
						// zero is never handed out: skip it on wrap
						if (exp.new_tag == 0) begin
							exp.new_tag = 1;
							next_tag    = 2;
						end
						tags[occ]    = exp.new_tag;
						occ++;
						exp.accepted = 1'b1;
					end
				end
				MODE_COMPLETE: begin
					if (phase == PH_CODE_RUNNING && t != 0) begin
						hit = -1;
						for (int i = 0; i < occ; i++)
							if (hit < 0 && tags[i] == t)
								hit = i;
						// close the gap behind the first match
						if (hit >= 0) begin
							for (int i = hit; i + 1 < occ; i++)
								tags[i] = tags[i + 1];
							occ--;
							tags[occ]    = '0;
							exp.accepted = 1'b1;
						end
					end
				end
				MODE_BEGIN_STOP: begin
					if (phase == PH_CODE_RUNNING) begin
						phase        = PH_CODE_STOPPING;
						exp.accepted = 1'b1;
					end
				end
				MODE_FINISH_STOP: begin
					if (phase == PH_CODE_STOPPING) begin
						clear_tags();
						phase        = PH_CODE_STOPPED;
						exp.accepted = 1'b1;
					end
				end
				MODE_REMOVE: begin
					if (phase == PH_CODE_ADDED || phase == PH_CODE_STOPPED) begin
						clear_stream();
						exp.accepted = 1'b1;
					end
				end
				default: begin
				end
			endcase
			exp.phase_now     = phase;
			exp.occupancy_now = OCC_OUT_W'(occ);
			status_q.push_back(exp);
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		// Compare one result transfer against the oldest prediction
		function void check_result(stream_status_t got);
			stream_status_t exp;
			if (status_q.size() == 0) begin
				report($sformatf("result with nothing expected: acc=%0b tag=%h ph=%0d occ=%0d",
					got.accepted, got.new_tag, got.phase_now, got.occupancy_now));
				return;
			end
			exp = status_q.pop_front();
			if (got.accepted !== exp.accepted)
				report($sformatf("accepted exp %0b got %0b", exp.accepted, got.accepted));
			if (got.new_tag !== exp.new_tag)
				report($sformatf("new_tag exp %h got %h", exp.new_tag, got.new_tag));
			if (got.phase_now !== exp.phase_now)
				report($sformatf("phase_now exp %0d got %0d", exp.phase_now, got.phase_now));
			if (got.occupancy_now !== exp.occupancy_now)
				report($sformatf("occupancy_now exp %0d got %0d",
					exp.occupancy_now, got.occupancy_now));
		endfunction

		function void flush_check();
			if (status_q.size() != 0)
				report($sformatf("%0d results never arrived", status_q.size()));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ibl_ev_if  ev_ch();
	ibl_rsp_if rsp_ch();

	iso_batch_lifecycle_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev_ch),
		.rsp    (rsp_ch)
	);

	lifecycle_scoreboard sb;
	bit                  calm_phase;
	bit                  rsp_hold_req;
	int unsigned         stall_cycles;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watch both channels; check results, note transferred events, trip on a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result({rsp_ch.accepted, rsp_ch.new_tag, rsp_ch.phase_now,
					rsp_ch.occupancy_now});
			if (ev_ch.valid && ev_ch.ready)
				sb.note_event(ev_ch.mode, ev_ch.tag_in);
			if ((ev_ch.valid && ev_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", stall_cycles);
				$display("FAIL iso_batch_lifecycle_tracker");
				$finish;
			end
		end
	end

	// Result receiver: random back-pressure, calm stretches, one long hold-off on request
	initial begin
		int hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				hold_left    = RSP_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm_phase) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 10);
			end
		end
	end

	// Offer one event and hold it until transferred; may first leave the channel idle
	task automatic send_event(input logic [MODE_W-1:0] m, input logic [TAG_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm_phase && $urandom_range(99) < 10)
			gap = 1;
		if (gap > 0) begin
			ev_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev_ch.valid  <= 1'b1;
		ev_ch.mode   <= m;
		ev_ch.tag_in <= t;
		@(posedge clk);
		while (!ev_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic wait_drained();
		ev_ch.valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pick the next event: mostly a legal lifecycle step, sometimes noise
	task automatic pick_event(output logic [MODE_W-1:0] m, output logic [TAG_W-1:0] t);
		int r;
		t = $urandom;
		r = $urandom_range(99);
		if ($urandom_range(99) < 15) begin
			m = MODE_W'($urandom_range(7));
			if ($urandom_range(3) == 0)
				t = '0;
			return;
		end
		case (sb.phase)
			PH_CODE_FREE:     m = MODE_ADD;
			PH_CODE_ADDED:    m = (r < 85) ? MODE_START : MODE_REMOVE;
			PH_CODE_STOPPING: m = MODE_FINISH_STOP;
			PH_CODE_STOPPED:  m = (r < 70) ? MODE_START : MODE_REMOVE;
			PH_CODE_RUNNING: begin
				if (r < 52) begin
					m = MODE_QUEUE;
				end else if (r < 85) begin
					m = MODE_COMPLETE;
					if (sb.occ > 0)
						t = sb.tags[$urandom_range(sb.occ - 1)];
				end else if (r < 93) begin
					// tag most likely not in flight
					m = MODE_COMPLETE;
				end else begin
					m = MODE_BEGIN_STOP;
				end
			end
			default: m = MODE_UNUSED;
		endcase
	endtask

	// Stimulus
	initial begin
		logic [MODE_W-1:0] m;
		logic [TAG_W-1:0]  t;
		sb           = new();
		calm_phase   = 1'b0;
		rsp_hold_req = 1'b0;
		stall_cycles = 0;
		ev_ch.valid  = 1'b0;
		ev_ch.mode   = MODE_ADD;
		ev_ch.tag_in = '0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: refusals in free, the full lifecycle, a full list, complete edge cases
		send_event(MODE_UNUSED, 32'hFFFF_FFFF);
		send_event(MODE_START, '0);
		send_event(MODE_ADD, '0);
		send_event(MODE_ADD, 32'hFFFF_FFFF);
		send_event(MODE_QUEUE, '0);
		send_event(MODE_START, '0);
		repeat (LIST_DEPTH + 1)
			send_event(MODE_QUEUE, 32'hA5A5_5A5A);
		send_event(MODE_COMPLETE, '0);
		send_event(MODE_COMPLETE, 32'hFFFF_FFFF);
		send_event(MODE_COMPLETE, 32'd3);
		send_event(MODE_COMPLETE, 32'd1);
		send_event(MODE_COMPLETE, 32'(LIST_DEPTH));
		send_event(MODE_BEGIN_STOP, '0);
		send_event(MODE_QUEUE, '0);
		send_event(MODE_FINISH_STOP, '0);
		send_event(MODE_REMOVE, '0);

		// Random lifecycle traffic
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n == 300)
				rsp_hold_req = 1'b1;
			if (n == 650)
				wait_drained();
			calm_phase = (n >= 900 && n < 1100);
			pick_event(m, t);
			send_event(m, t);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_check();
		if (sb.errors == 0)
			$display("PASS iso_batch_lifecycle_tracker");
		else
			$display("FAIL iso_batch_lifecycle_tracker");
		$finish;
	end

endmodule

// File: iso_batch_lifecycle_tracker.f
rtl/core/ibl_pkg.sv
rtl/core/ibl_if.sv
rtl/core/ibl_cell.sv
rtl/core/ibl_chain.sv
rtl/core/iso_batch_lifecycle_tracker.sv
rtl/core/ibl_checker.sv
bench/tb.sv
